### src/klex_pkg.sv
// Package for the keyword lexer: request and token types, token kind codes,
// scan modes, and keyword and operator tables. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package klex_pkg;

	// One source request: a byte, or the end-of-source marker.
	typedef struct packed {
		logic [7:0] ch;
		logic       is_end;
	} klex_char_t;

	// One token as delivered on the output channel.
	typedef struct packed {
		logic [4:0]  kind;
		logic [23:0] line_no;
		logic [31:0] start_offset;
		logic [6:0]  length;
		logic [7:0]  text_char;
		logic        last;
	} klex_token_t;

	// Scanner modes.
	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_NUM   = 2'd1,
		MODE_IDENT = 2'd2,
		MODE_ENDED = 2'd3
	} klex_mode_t;

	// Token kind codes.
	localparam logic [4:0] KIND_EOF   = 5'd0;
	localparam logic [4:0] KIND_NUM   = 5'd1;
	localparam logic [4:0] KIND_IDENT = 5'd2;
	localparam logic [4:0] KIND_KW0   = 5'd3;
	localparam logic [4:0] KIND_PLUS  = 5'd8;
	localparam logic [4:0] KIND_MINUS = 5'd9;
	localparam logic [4:0] KIND_STAR  = 5'd10;
	localparam logic [4:0] KIND_SLASH = 5'd11;
	localparam logic [4:0] KIND_ASSIGN = 5'd12;
	localparam logic [4:0] KIND_GT    = 5'd13;
	localparam logic [4:0] KIND_LT    = 5'd14;
	localparam logic [4:0] KIND_LPAREN = 5'd15;
	localparam logic [4:0] KIND_RPAREN = 5'd16;
	localparam logic [4:0] KIND_LBRACE = 5'd17;
	localparam logic [4:0] KIND_RBRACE = 5'd18;
	localparam logic [4:0] KIND_SEMI  = 5'd19;
	localparam logic [4:0] KIND_BAD   = 5'd20;

	localparam int          NUM_KW    = 5;
	localparam logic [4:0]  KW_ALL    = 5'b11111;
	localparam logic [7:0]  CHAR_NUL  = 8'h00;
	localparam logic [7:0]  CHAR_LF   = 8'h0A;
	localparam logic [7:0]  CHAR_USCORE = 8'h5F;
	localparam logic [23:0] LINE_FIRST = 24'd1;

	// Keywords, in kind order: int, if, else, while, print.
	localparam logic [7:0] KW_TEXT [0:4][0:4] = '{
		'{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00},
		'{8'h69, 8'h66, 8'h00, 8'h00, 8'h00},
		'{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00},
		'{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65},
		'{8'h70, 8'h72, 8'h69, 8'h6E, 8'h74}
	};
	localparam logic [2:0] KW_LEN [0:4] = '{3'd3, 3'd2, 3'd4, 3'd5, 3'd5};

	// Maps an operator byte to its kind; anything else is invalid.
	function automatic logic [4:0] op_kind(input logic [7:0] c);
		logic [4:0] k;
		begin
			case (c)
				8'h2B: k = KIND_PLUS;
				8'h2D: k = KIND_MINUS;
				8'h2A: k = KIND_STAR;
				8'h2F: k = KIND_SLASH;
				8'h3D: k = KIND_ASSIGN;
				8'h3E: k = KIND_GT;
				8'h3C: k = KIND_LT;
				8'h28: k = KIND_LPAREN;
				8'h29: k = KIND_RPAREN;
				8'h7B: k = KIND_LBRACE;
				8'h7D: k = KIND_RBRACE;
				8'h3B: k = KIND_SEMI;
				default: k = KIND_BAD;
			endcase
			return k;
		end
	endfunction

	// Clears the keyword candidates that do not have byte c at position pos.
	function automatic logic [4:0] kw_match(input logic [4:0] hits, input logic [7:0] c,
			input logic [6:0] pos);
		logic [4:0] h;
		begin
			h = hits;
			for (int k = 0; k < NUM_KW; k++) begin
				if (pos >= 7'(KW_LEN[k])) begin
					h[k] = 1'b0;
				end else if (KW_TEXT[k][pos[2:0]] != c) begin
					h[k] = 1'b0;
				end
			end
			return h;
		end
	endfunction

endpackage

`default_nettype wire

### src/klex_stream_if.sv
// Valid/ready stream interface used by both lexer channels.
// Payload type is a parameter; the types come from klex_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface klex_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/keyword_lexer_top.sv
// Keyword lexer: takes one source byte (or an end marker) per request and
// accepts a new request every cycle while its four-entry token queue has room
// for two tokens, so a steady byte stream runs at one byte per cycle; a request
// that yields two tokens (pending word or number plus an operator, invalid
// byte or EOF) takes two queue entries, and the queue depth sets how
// many such requests can be absorbed before chars.ready drops. Tokens carry
// kind, line, start offset, length and the operator byte. After an invalid
// byte or a NUL all bytes are dropped until the end marker restarts the source.
// Depends on klex_pkg and klex_stream_if.
`timescale 1ns / 1ps
`default_nettype none

module keyword_lexer_top #(
	parameter int MAX_TOKEN_LEN = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	klex_stream_if.sink         chars,
	klex_stream_if.source       tokens
);
	import klex_pkg::*;

	localparam int         CapInt = (MAX_TOKEN_LEN > 127) ? 127 : MAX_TOKEN_LEN;
	localparam logic [6:0] LenCap = 7'(CapInt);

	// Scanner state.
	klex_mode_t  mode_q, mode_d;
	logic [23:0] line_q, line_d;
	logic [31:0] offset_q, offset_d;
	logic [31:0] start_q, start_d;
	logic [6:0]  len_q, len_d;
	logic [4:0]  hits_q, hits_d;
	logic        error_q, error_d;

	// Token queue.
	klex_token_t queue_q [0:3];
	logic [1:0]  wr_q, rd_q;
	logic [2:0]  count_q;

	logic        in_acc, out_acc;
	logic [7:0]  c;
	logic        is_end, is_digit, is_alpha, is_word, is_space;
	logic        pend;
	logic [4:0]  flush_kind;
	klex_token_t tok_flush, tok_eof, tok_op;
	klex_token_t res0, res1;
	logic [1:0]  push_n;

	assign in_acc      = chars.valid && chars.ready;
	assign out_acc     = tokens.valid && tokens.ready;
	assign chars.ready = (count_q <= 3'd2);
	assign c           = chars.data.ch;
	assign is_end      = chars.data.is_end;

	// Character classes.
	always_comb begin
		is_digit = c inside {[8'h30:8'h39]};
		is_alpha = c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
		is_word  = is_digit || is_alpha || (c == CHAR_USCORE);
		is_space = c inside {8'h20, [8'h09:8'h0D]};
	end

	// Kind of the pending word or number: the first keyword still among the candidates whose length matches wins.
	always_comb begin
		flush_kind = KIND_NUM;
		if (mode_q == MODE_IDENT) begin
			flush_kind = KIND_IDENT;
			for (int k = NUM_KW - 1; k >= 0; k--) begin
				if (hits_q[k] && (len_q == 7'(KW_LEN[k]))) begin
					flush_kind = KIND_KW0 + 5'(k);
				end
			end
		end
		pend = (mode_q == MODE_NUM) || (mode_q == MODE_IDENT);
	end

	// Candidate tokens for this request.
	always_comb begin
		tok_flush = '{kind: flush_kind, line_no: line_q, start_offset: start_q,
			length: len_q, text_char: CHAR_NUL, last: 1'b0};
		tok_eof = '{kind: KIND_EOF, line_no: line_q, start_offset: offset_q,
			length: 7'd0, text_char: CHAR_NUL, last: 1'b0};
		tok_op = '{kind: op_kind(c), line_no: line_q, start_offset: offset_q,
			length: 7'd1, text_char: c, last: 1'b0};
	end

	// Next scanner state and the tokens pushed for this request.
	always_comb begin
		mode_d   = mode_q;
		line_d   = line_q;
		offset_d = offset_q;
		start_d  = start_q;
		len_d    = len_q;
		hits_d   = hits_q;
		error_d  = error_q;
		res0     = tok_flush;
		res1     = tok_eof;
		push_n   = 2'd0;
		if (in_acc) begin
			if (error_q || (mode_q == MODE_ENDED)) begin
				// Dropping bytes; only the end marker restarts the source.
				if (is_end) begin
					mode_d   = MODE_IDLE;
					line_d   = LINE_FIRST;
					offset_d = '0;
					start_d  = '0;
					len_d    = '0;
					hits_d   = KW_ALL;
					error_d  = 1'b0;
				end
			end else if (is_end || (c == CHAR_NUL)) begin
				// End of source: pending token, then EOF.
				if (pend) begin
					push_n = 2'd2;
				end else begin
					res0   = tok_eof;
					push_n = 2'd1;
				end
				len_d  = '0;
				hits_d = KW_ALL;
				if (is_end) begin
					mode_d   = MODE_IDLE;
					line_d   = LINE_FIRST;
					offset_d = '0;
					start_d  = '0;
				end else begin
					mode_d = MODE_ENDED;
				end
			end else begin
				if ((mode_q == MODE_NUM) && is_digit) begin
					if (len_q < LenCap) len_d = len_q + 7'd1;
				end else if ((mode_q == MODE_IDENT) && is_word) begin
					hits_d = kw_match(hits_q, c, len_q);
					if (len_q < LenCap) len_d = len_q + 7'd1;
				end else begin
					// Close any pending token, then start on this byte.
					mode_d = MODE_IDLE;
					len_d  = '0;
					hits_d = KW_ALL;
					if (pend) push_n = 2'd1;
					if (is_space) begin
						if ((c == CHAR_LF) && (line_q != '1)) line_d = line_q + 24'd1;
					end else if (is_digit) begin
						mode_d  = MODE_NUM;
						start_d = offset_q;
						len_d   = 7'd1;
					end else if (is_alpha || (c == CHAR_USCORE)) begin
						mode_d  = MODE_IDENT;
						start_d = offset_q;
						hits_d  = kw_match(KW_ALL, c, 7'd0);
						len_d   = 7'd1;
					end else begin
						if (pend) begin
							res1   = tok_op;
							push_n = 2'd2;
						end else begin
							res0   = tok_op;
							push_n = 2'd1;
						end
						if (op_kind(c) == KIND_BAD) error_d = 1'b1;
					end
				end
				if (offset_q != '1) offset_d = offset_q + 32'd1;
			end
		end
		// Mark the final token of this request.
		if (push_n == 2'd1) res0.last = 1'b1;
		if (push_n == 2'd2) res1.last = 1'b1;
	end

	// Scanner state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			line_q   <= LINE_FIRST;
			offset_q <= '0;
			start_q  <= '0;
			len_q    <= '0;
			hits_q   <= KW_ALL;
			error_q  <= 1'b0;
		end else begin
			mode_q   <= mode_d;
			line_q   <= line_d;
			offset_q <= offset_d;
			start_q  <= start_d;
			len_q    <= len_d;
			hits_q   <= hits_d;
			error_q  <= error_d;
		end
	end

	// Token queue storage.
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) queue_q[wr_q] <= res0;
		if (push_n == 2'd2) queue_q[wr_q + 2'd1] <= res1;
	end

	// Token queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + push_n;
			if (out_acc) rd_q <= rd_q + 2'd1;
			count_q <= count_q + {1'b0, push_n} - {2'b00, out_acc};
		end
	end

	assign tokens.valid = (count_q != 3'd0);
	assign tokens.data  = queue_q[rd_q];

`ifndef SYNTHESIS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("token queue overfilled");

	a_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		chars.valid && chars.ready && chars.data.is_end |=>
		mode_q == MODE_IDLE && offset_q == 32'd0 && line_q == LINE_FIRST && !error_q)
		else $error("end marker did not restart the source");

	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LenCap)
		else $error("token length beyond its cap");

	a_eof_shape: assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid && tokens.data.kind == KIND_EOF |->
		tokens.data.length == 7'd0 && tokens.data.last)
		else $error("EOF token malformed");
`endif

endmodule

`default_nettype wire
